@@ rtl/base85_stream_codec_core_assert.svh @@
// Assertion macros for the base85 stream codec core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BASE85_STREAM_CODEC_CORE_ASSERT_SVH
`define BASE85_STREAM_CODEC_CORE_ASSERT_SVH

// same-cycle implication
`define B85SC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define B85SC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/b85sc_pkg.sv @@
// Shared types, constants and alphabet functions for the base85 codec.
// No dependencies.
`default_nettype none
package b85sc_pkg;

    localparam int DIGW = 7;
    localparam int NDIG = 5;

    localparam logic [7:0] CH_Z = 8'h7A;
    localparam logic [6:0] DIV_LOW = 7'd84;
    localparam logic [6:0] DIV_HIGH = 7'd85;
    // floor(2^38 / divisor)
    localparam logic [31:0] RECIP_LOW = 32'd3272356035;
    localparam logic [31:0] RECIP_HIGH = 32'd3233857728;
    localparam int RECIP_SHIFT = 38;

    typedef enum logic [1:0] {
        JOB_ENC,
        JOB_DEC,
        JOB_LIT
    } job_kind_t;

    typedef struct packed {
        job_kind_t kind;
        logic [NDIG*DIGW-1:0] value;
        logic [2:0] count;
    } job_t;

    typedef struct packed {
        logic ok;
        logic [DIGW-1:0] digit;
    } lookup_t;

    function automatic lookup_t digit_of(input logic [7:0] c, input logic lead);
        lookup_t r;
        r.ok = 1'b1;
        r.digit = '0;
        if (c inside {[8'h30:8'h39]})
            r.digit = 7'(c - 8'h30);
        else if (c inside {[8'h41:8'h5A]})
            r.digit = 7'(c - 8'h41 + 8'd10);
        else if (c inside {[8'h61:8'h79]})
            r.digit = 7'(c - 8'h61 + 8'd36);
        else begin
            case (c)
                8'h21: r.digit = 7'd61;
                8'h23: r.digit = 7'd62;
                8'h24: r.digit = 7'd63;
                8'h28: r.digit = 7'd64;
                8'h29: r.digit = 7'd65;
                8'h2A: r.digit = 7'd66;
                8'h2B: r.digit = 7'd67;
                8'h2C: r.digit = 7'd68;
                8'h2D: r.digit = 7'd69;
                8'h2E: r.digit = 7'd70;
                8'h2F: r.digit = 7'd71;
                8'h3A: r.digit = 7'd72;
                8'h3B: r.digit = 7'd73;
                8'h3D: r.digit = 7'd74;
                8'h3F: r.digit = 7'd75;
                8'h40: r.digit = 7'd76;
                8'h5E: r.digit = 7'd77;
                8'h60: r.digit = 7'd78;
                8'h7B: r.digit = 7'd79;
                8'h7C: r.digit = 7'd80;
                8'h7D: r.digit = 7'd81;
                8'h7E: r.digit = 7'd82;
                8'h7A: r.digit = lead ? 7'd84 : 7'd83;
                8'h5F: r.digit = lead ? 7'd83 : 7'd84;
                default: r.ok = 1'b0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [7:0] char_of(input logic [DIGW-1:0] d, input logic lead);
        logic [7:0] c;
        c = 8'h30;
        if (d < 7'd10)
            c = 8'h30 + 8'(d);
        else if (d < 7'd36)
            c = 8'h41 + 8'(d - 7'd10);
        else if (d < 7'd61)
            c = 8'h61 + 8'(d - 7'd36);
        else begin
            case (d)
                7'd61: c = 8'h21;
                7'd62: c = 8'h23;
                7'd63: c = 8'h24;
                7'd64: c = 8'h28;
                7'd65: c = 8'h29;
                7'd66: c = 8'h2A;
                7'd67: c = 8'h2B;
                7'd68: c = 8'h2C;
                7'd69: c = 8'h2D;
                7'd70: c = 8'h2E;
                7'd71: c = 8'h2F;
                7'd72: c = 8'h3A;
                7'd73: c = 8'h3B;
                7'd74: c = 8'h3D;
                7'd75: c = 8'h3F;
                7'd76: c = 8'h40;
                7'd77: c = 8'h5E;
                7'd78: c = 8'h60;
                7'd79: c = 8'h7B;
                7'd80: c = 8'h7C;
                7'd81: c = 8'h7D;
                7'd82: c = 8'h7E;
                7'd83: c = lead ? 8'h5F : 8'h7A;
                7'd84: c = lead ? 8'h7A : 8'h5F;
                default: c = 8'h30;
            endcase
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/base85_stream_codec_core.sv @@
// Top level of the base85 stream codec: APB register, front end, job
// queue and back end. Depends on b85sc_pkg and the front/queue/back modules.
//
// Usage: direction register at address 0 (0 encode, 1 decode); writing it
// clears any partial group. Write only while idle. Input words on
// in_valid/in_ready (data_byte, is_final), results on out_valid/out_ready
// (out_byte, run_end marks the last result of an input word).
// Input words that do not complete a group are taken one per cycle while
// the queue is not full. An encoded group runs each digit through the
// reciprocal-multiply divider (multiply, then fix-up), then emits one
// character per digit. A decoded group accumulates a digit per cycle, then
// emits bytes; a literal ('z' in either direction) goes straight to output.
// The job queue holds QUEUE_DEPTH groups so the front keeps accepting while
// the back end works; the front stalls only when the queue is full.
// A stalled receiver holds the output register and the back end waits.
// Reset clears the direction, the partial group, the queue and the output.
`default_nettype none
`include "base85_stream_codec_core_assert.svh"
module base85_stream_codec_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        is_final,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             run_end,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import b85sc_pkg::*;

    logic  dir_reg;
    logic  cfg_clear;
    logic  q_full, q_nonempty, q_pop, push;
    job_t  push_job, head_job;

    assign pready    = 1'b1;
    assign cfg_clear = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {31'd0, dir_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dir_reg <= 1'b0;
        else if (cfg_clear)
            dir_reg <= pwdata[0];
    end

    b85sc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .dir       (dir_reg),
        .cfg_clear (cfg_clear),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .is_final  (is_final),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job)
    );

    b85sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head_job (head_job)
    );

    b85sc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .head_job   (head_job),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_end    (run_end)
    );

    `B85SC_ASSERT_IMP(a_job_count, push, push_job.count >= 3'd1 && push_job.count <= 3'd5, "job count out of range")
    `B85SC_ASSERT_IMP(a_enc_count, push && push_job.kind == JOB_ENC, push_job.count <= 3'd4, "encode group too long")
    `B85SC_ASSERT_NXT(a_enc_dir, push && push_job.kind == JOB_ENC && !cfg_clear, !dir_reg, "encode job while decoding")

endmodule
`default_nettype wire

@@ rtl/b85sc_front.sv @@
// Front end: accepts words, gathers groups, issues jobs to the queue.
// Depends on b85sc_pkg.
`default_nettype none
module b85sc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              dir,
    input  wire logic              cfg_clear,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        data_byte,
    input  wire logic              is_final,
    input  wire logic              q_full,
    output logic                   push,
    output b85sc_pkg::job_t        job
);
    import b85sc_pkg::*;

    logic [31:0]     acc_reg, acc_next;
    logic [2:0]      pos_reg, pos_next;
    logic [DIGW-1:0] digs_reg [NDIG];
    logic [DIGW-1:0] digs_next [NDIG];
    logic [31:0]     acc_in;
    logic [2:0]      pos_inc;
    lookup_t         lk;
    logic [NDIG*DIGW-1:0] packed_next, packed_cur;

    assign in_ready = !q_full;
    assign acc_in   = {acc_reg[23:0], data_byte};
    assign pos_inc  = pos_reg + 3'd1;
    assign lk       = digit_of(data_byte, pos_reg == 3'd0);

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            packed_cur[i*DIGW +: DIGW] = digs_reg[i];
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        pos_next = pos_reg;
        for (int i = 0; i < NDIG; i++)
            digs_next[i] = digs_reg[i];
        push = 1'b0;
        job.kind = JOB_LIT;
        job.value = '0;
        job.count = 3'd1;
        if (in_valid && !q_full)
        begin
            if (!dir)
            begin
                if (pos_inc == 3'd4)
                begin
                    push = 1'b1;
                    if (acc_in == 32'd0)
                    begin
                        job.kind = JOB_LIT;
                        job.value = (NDIG*DIGW)'(CH_Z);
                        job.count = 3'd1;
                    end
                    else
                    begin
                        job.kind = JOB_ENC;
                        job.value = (NDIG*DIGW)'(acc_in);
                        job.count = 3'd4;
                    end
                    acc_next = '0;
                    pos_next = '0;
                end
                else if (is_final)
                begin
                    push = 1'b1;
                    job.kind = JOB_ENC;
                    job.value = (NDIG*DIGW)'(acc_in);
                    job.count = pos_inc;
                    acc_next = '0;
                    pos_next = '0;
                end
                else
                begin
                    acc_next = acc_in;
                    pos_next = pos_inc;
                end
            end
            else
            begin
                if (pos_reg == 3'd0 && data_byte == CH_Z)
                begin
                    push = 1'b1;
                    job.kind = JOB_LIT;
                    job.value = '0;
                    job.count = 3'd4;
                end
                else if (lk.ok)
                begin
                    digs_next[pos_reg] = lk.digit;
                    if (pos_inc == 3'd5 || is_final)
                    begin
                        push = 1'b1;
                        job.kind = JOB_DEC;
                        job.value = packed_next;
                        job.count = pos_inc;
                        pos_next = '0;
                    end
                    else
                        pos_next = pos_inc;
                end
                else if (is_final && pos_reg != 3'd0)
                begin
                    push = 1'b1;
                    job.kind = JOB_DEC;
                    job.value = packed_cur;
                    job.count = pos_reg;
                    pos_next = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
            packed_next[i*DIGW +: DIGW] = digs_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
            for (int i = 0; i < NDIG; i++)
                digs_reg[i] <= '0;
        end
        else if (cfg_clear)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
            for (int i = 0; i < NDIG; i++)
                digs_reg[i] <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            for (int i = 0; i < NDIG; i++)
                digs_reg[i] <= digs_next[i];
        end
    end

endmodule
`default_nettype wire

@@ rtl/b85sc_queue.sv @@
// Job queue between front and back end.
// Depends on b85sc_pkg.
`default_nettype none
module b85sc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  b85sc_pkg::job_t        push_job,
    input  wire logic              pop,
    output logic                   full,
    output logic                   nonempty,
    output b85sc_pkg::job_t        head_job
);
    import b85sc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full     = count_reg == CW'(DEPTH);
    assign nonempty = count_reg != '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign head_job = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule
`default_nettype wire

@@ rtl/b85sc_back.sv @@
// Back end: digit extraction by reciprocal multiply, digit accumulation,
// and one-word-per-cycle output register while out_ready holds. Depends on b85sc_pkg.
`default_nettype none
module b85sc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_nonempty,
    input  b85sc_pkg::job_t        head_job,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   run_end
);
    import b85sc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_DACC,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic [31:0]          v_reg;
    logic [63:0]          prod_reg;
    logic [DIGW-1:0]      dig_reg [NDIG];
    logic [NDIG*DIGW-1:0] src_reg;
    logic [2:0]           idx_reg;
    logic [2:0]           cnt_reg;
    logic                 chars_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 run_end_reg;

    logic [6:0]           div;
    logic [25:0]          q0;
    logic [31:0]          qd, r0, r_fix, q_fix;
    logic [DIGW-1:0]      src_dig;
    logic [31:0]          v_acc;
    logic                 acc_last;
    logic [31:0]          v_hi;
    logic [2:0]           emit_cnt;
    logic [7:0]           emit_byte;
    logic                 can_load;

    assign q_pop     = (state_reg == ST_IDLE) && q_nonempty;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_end   = run_end_reg;
    assign can_load  = !out_valid_reg || out_ready;

    // quotient estimate is low by at most one
    assign div = (idx_reg == 3'd0) ? DIV_LOW : DIV_HIGH;
    assign q0  = prod_reg[63:RECIP_SHIFT];
    assign qd  = 32'(q0) * 32'(div);
    assign r0  = v_reg - qd;

    always_comb
    begin
        if (r0 >= 32'(div))
        begin
            r_fix = r0 - 32'(div);
            q_fix = 32'(q0) + 32'd1;
        end
        else
        begin
            r_fix = r0;
            q_fix = 32'(q0);
        end
    end

    assign src_dig  = src_reg[7*idx_reg +: DIGW];
    assign acc_last = idx_reg == cnt_reg - 3'd1;

    always_comb
    begin
        if (idx_reg == 3'd0)
            v_acc = 32'(src_dig);
        else if (acc_last)
            v_acc = v_reg * 32'(DIV_LOW) + 32'(src_dig);
        else
            v_acc = v_reg * 32'(DIV_HIGH) + 32'(src_dig);
    end

    assign v_hi = v_acc >> {cnt_reg - 3'd1, 3'b000};

    always_comb
    begin
        if (cnt_reg == 3'd1)
            emit_cnt = 3'd1;
        else if (cnt_reg != 3'd5 && v_hi != 32'd0)
            emit_cnt = cnt_reg;
        else
            emit_cnt = cnt_reg - 3'd1;
    end

    always_comb
    begin
        if (chars_reg)
            emit_byte = char_of(dig_reg[idx_reg], idx_reg == cnt_reg - 3'd1);
        else
            emit_byte = v_reg[8*idx_reg[1:0] +: 8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            run_end_reg   <= 1'b0;
            v_reg         <= '0;
            prod_reg      <= '0;
            src_reg       <= '0;
            for (int i = 0; i < NDIG; i++)
                dig_reg[i] <= '0;
            idx_reg       <= '0;
            cnt_reg       <= 3'd1;
            chars_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != ST_EMIT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_nonempty)
                    begin
                        case (head_job.kind)
                            JOB_ENC:
                            begin
                                v_reg     <= head_job.value[31:0];
                                cnt_reg   <= head_job.count + 3'd1;
                                idx_reg   <= '0;
                                chars_reg <= 1'b1;
                                state_reg <= ST_MUL;
                            end
                            JOB_DEC:
                            begin
                                src_reg   <= head_job.value;
                                cnt_reg   <= head_job.count;
                                idx_reg   <= '0;
                                v_reg     <= '0;
                                chars_reg <= 1'b0;
                                state_reg <= ST_DACC;
                            end
                            JOB_LIT:
                            begin
                                v_reg     <= head_job.value[31:0];
                                cnt_reg   <= head_job.count;
                                idx_reg   <= head_job.count - 3'd1;
                                chars_reg <= 1'b0;
                                state_reg <= ST_EMIT;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= 64'(v_reg) *
                                 64'((idx_reg == 3'd0) ? RECIP_LOW : RECIP_HIGH);
                    state_reg <= ST_FIX;
                end
                ST_FIX:
                begin
                    dig_reg[idx_reg] <= r_fix[DIGW-1:0];
                    v_reg            <= q_fix;
                    if (idx_reg == cnt_reg - 3'd1)
                        state_reg <= ST_EMIT;
                    else
                    begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_DACC:
                begin
                    v_reg <= v_acc;
                    if (acc_last)
                    begin
                        cnt_reg   <= emit_cnt;
                        idx_reg   <= emit_cnt - 3'd1;
                        state_reg <= ST_EMIT;
                    end
                    else
                        idx_reg <= idx_reg + 3'd1;
                end
                ST_EMIT:
                begin
                    if (can_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_byte_reg  <= emit_byte;
                        run_end_reg   <= idx_reg == 3'd0;
                        if (idx_reg == 3'd0)
                            state_reg <= ST_IDLE;
                        else
                            idx_reg <= idx_reg - 3'd1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ bench/base85_stream_codec_core_chk.sv @@
// Checker for the base85 stream codec core: watches the word channels,
// predicts the codec output and compares it. No package dependencies.
module base85_stream_codec_core_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_final,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic        run_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_DIRECTION = 3'd0;
    localparam string NORM_ALPHA =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxy!#$()*+,-./:;=?@^`{|}~z_";
    localparam string LEAD_ALPHA =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxy!#$()*+,-./:;=?@^`{|}~_z";

    logic        dir_decode;
    logic [31:0] byte_acc;
    logic [6:0]  digits [5];
    int          grp_pos;
    logic [8:0]  expected_chars [$];

    assign pending = expected_chars.size();

    function automatic int alpha_index(string alpha, logic [7:0] c);
        for (int i = 0; i < 85; i++)
            if (alpha[i] == c)
                return i;
        return -1;
    endfunction

    function automatic void clear_group();
        byte_acc = '0;
        grp_pos = 0;
        for (int i = 0; i < 5; i++)
            digits[i] = '0;
    endfunction

    task automatic encode_group(logic [31:0] v, int nbytes);
        int d [5];
        int nd;
        nd = nbytes + 1;
        d[0] = v % 84;
        v = v / 84;
        for (int i = 1; i < nd; i++)
        begin
            d[i] = v % 85;
            v = v / 85;
        end
        expected_chars.push_back({1'b0, 8'(LEAD_ALPHA[d[nd-1]])});
        for (int i = nd - 1; i > 0; i--)
            expected_chars.push_back({1'b0, 8'(NORM_ALPHA[d[i-1]])});
    endtask

    task automatic decode_group(int m);
        logic [31:0] v;
        int nb;
        if (m == 1)
        begin
            expected_chars.push_back({1'b0, 1'b0, digits[0]});
            return;
        end
        v = 32'(digits[0]);
        for (int i = 1; i + 1 < m; i++)
            v = v * 85 + digits[i];
        v = v * 84 + digits[m-1];
        nb = m - 1;
        if (nb < 4 && (v >> (8 * nb)) != 0)
            expected_chars.push_back({1'b0, 8'(v >> (8 * nb))});
        for (int k = nb; k > 0; k--)
            expected_chars.push_back({1'b0, 8'(v >> (8 * (k - 1)))});
    endtask

    task automatic predict_word(logic [7:0] c, logic fin);
        int n_before;
        int d;
        int p;
        n_before = expected_chars.size();
        if (!dir_decode)
        begin
            byte_acc = {byte_acc[23:0], c};
            grp_pos++;
            if (grp_pos >= 4)
            begin
                if (byte_acc == 0)
                    expected_chars.push_back({1'b0, 8'h7A});
                else
                    encode_group(byte_acc, 4);
                clear_group();
            end
            else if (fin)
            begin
                encode_group(byte_acc, grp_pos);
                clear_group();
            end
        end
        else
        begin
            p = grp_pos;
            d = alpha_index(p == 0 ? LEAD_ALPHA : NORM_ALPHA, c);
            if (d >= 0)
            begin
                if (p == 0 && c == 8'h7A)
                begin
                    repeat (4)
                        expected_chars.push_back(9'h000);
                end
                else
                begin
                    digits[p] = 7'(d);
                    p++;
                    if (p == 5)
                    begin
                        decode_group(5);
                        p = 0;
                    end
                end
            end
            if (fin && p > 0)
            begin
                decode_group(p);
                p = 0;
            end
            grp_pos = p;
            if (p == 0)
                clear_group();
        end
        if (expected_chars.size() > n_before)
            expected_chars[$][8] = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [8:0] exp_c;
        if (!rst_n)
        begin
            dir_decode = 1'b0;
            clear_group();
            expected_chars.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_DIRECTION)
            begin
                dir_decode = pwdata[0];
                clear_group();
            end
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected word out_byte=%h run_end=%b",
                             $realtime, out_byte, run_end);
                    errors++;
                end
                else
                begin
                    exp_c = expected_chars.pop_front();
                    if (out_byte !== exp_c[7:0] || run_end !== exp_c[8])
                    begin
                        $display("%0t: mismatch expected byte=%h end=%b actual byte=%h end=%b",
                                 $realtime, exp_c[7:0], exp_c[8], out_byte, run_end);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_word(data_byte, is_final);
        end
    end
endmodule

@@ bench/base85_stream_codec_core_tb.sv @@
// Testbench top for the base85 stream codec core: drives words and the
// direction register under varying idle/stall phases. Needs the checker and the RTL.
module base85_stream_codec_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_DIRECTION = 3'd0;
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;
    localparam string ALPHA_CHARS =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxy!#$()*+,-./:;=?@^`{|}~z_";

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        is_final = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        run_end;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    always #4 clk = ~clk;

    base85_stream_codec_core dut (.*);

    base85_stream_codec_core_chk checker_i (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .is_final(is_final), .out_valid(out_valid),
        .out_ready(out_ready), .out_byte(out_byte), .run_end(run_end),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
    );

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(logic [7:0] b, logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        is_final <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (30)
            @(posedge clk);
    endtask

    task automatic write_direction(logic dir);
        drain();
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_DIRECTION;
        pwdata <= {31'b0, dir};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return 8'(ALPHA_CHARS[$urandom_range(84)]);
        return 8'($urandom_range(255));
    endfunction

    task automatic random_encode(int n);
        for (int i = 0; i < n; i++)
            case ($urandom_range(3))
                0: send_word(8'h00, $urandom_range(9) == 0);
                1: send_word(8'hFF, $urandom_range(9) == 0);
                default: send_word(8'($urandom_range(255)), $urandom_range(7) == 0);
            endcase
    endtask

    task automatic random_decode(int n);
        for (int i = 0; i < n; i++)
            send_word(pick_char(), $urandom_range(7) == 0);
    endtask

    initial
    begin
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // encode directed: zero word, max word, partials incl. zero partial
        send_word(8'h00, 0); send_word(8'h00, 0); send_word(8'h00, 0); send_word(8'h00, 0);
        send_word(8'hFF, 0); send_word(8'hFF, 0); send_word(8'hFF, 0); send_word(8'hFF, 0);
        send_word(8'h00, 1);
        send_word(8'hFF, 0); send_word(8'hFF, 1);
        send_word(8'h00, 0); send_word(8'h00, 0); send_word(8'h00, 1);
        send_word(8'h12, 0); send_word(8'h34, 0); send_word(8'h56, 0); send_word(8'h78, 1);

        write_direction(DIR_DECODE);
        // decode directed: lead z, max digits (wrap), invalid, partials, mid z
        send_word("z", 0);
        send_word("_", 0); send_word("_", 0); send_word("_", 0); send_word("_", 0);
        send_word("_", 0);
        send_word("~", 1);
        send_word("_", 0); send_word("z", 0); send_word(8'h20, 1);
        send_word("_", 0); send_word("_", 0); send_word("_", 1);
        send_word(8'h80, 1);

        // partial group dropped by a direction write
        send_word("A", 0);
        write_direction(DIR_DECODE);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 61; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 61; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            write_direction(DIR_ENCODE);
            random_encode(50);
            write_direction(DIR_DECODE);
            random_decode(50);
        end

        send_idle_pct = 0;
        stall_pct = 0;
        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
